FILE: sv/atrm_pkg.sv
`default_nettype none

package atrm_pkg;

   localparam int unsigned ReplyMax     = 8;
   localparam int unsigned LineMax      = 19;
   localparam int unsigned CharLow      = 25;   // bytes must lie above this
   localparam int unsigned CharHigh     = 128;  // and below this
   localparam int unsigned LineLenWidth = $clog2(LineMax + 1);
   localparam int unsigned ReplyWidth   = 64;
   localparam int unsigned RlenWidth    = 4;
   localparam int unsigned TimeWidth    = 32;
   localparam int unsigned TryWidth     = 8;
   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 64;

   typedef enum logic [1:0] {
      CMD_START = 2'd0,
      CMD_BYTE  = 2'd1,
      CMD_TICK  = 2'd2
   } cmd_type;

   typedef enum logic [1:0] {
      EV_SEND  = 2'd0,
      EV_MATCH = 2'd1,
      EV_FAIL  = 2'd2
   } event_type;

   typedef enum logic [CsrAddrWidth-1:0] {
      REG_EXPECTED_REPLY = 2'd0,
      REG_REPLY_LENGTH   = 2'd1,
      REG_TIMEOUT_MS     = 2'd2,
      REG_MAX_TRIES      = 2'd3
   } csr_index_type;

   typedef struct packed {
      event_type                event_res;
      logic [TryWidth-1:0]      attempt;
   } result_type;

   localparam logic [ReplyWidth-1:0] ReplyReset   = 64'd19279;
   localparam logic [RlenWidth-1:0]  RlenReset    = 4'd2;
   localparam logic [TimeWidth-1:0]  TimeoutReset = 32'd1000;
   localparam logic [TryWidth-1:0]   TriesReset   = 8'd1;

endpackage

`default_nettype wire

FILE: sv/at_reply_matcher_with_retry.sv
`default_nettype none

// Channel | dir | tdata (low bit up)  | tuser (low bit up)
// req_    | in  | [7:0] rx_byte       | [1:0] cmd
// rsp_    | out | [7:0] attempt       | [1:0] event_res
// csr_    | in  | csr_wdata[63:0] by csr_addr, written when csr_we is high
//
// One item per cycle while req_tready is high: every item is decoded and
// applied to the exchange state in the cycle it is accepted; a result lands
// in the output register, visible on the next cycle, or else in the skid entry.
// A two-entry output buffer (output register plus skid) keeps req_tready high
// while one result waits; it drops only when both entries are full.
// Synchronous active-high reset restores the register defaults and closes
// any open exchange.
module at_reply_matcher_with_retry (
   input  wire                               clock,
   input  wire                               reset,
   input  wire                               req_tvalid,
   output logic                              req_tready,
   input  wire  [7:0]                        req_tdata,   // [7:0] rx_byte
   input  wire  [1:0]                        req_tuser,   // [1:0] cmd
   output logic                              rsp_tvalid,
   input  wire                               rsp_tready,
   output logic [7:0]                        rsp_tdata,   // [7:0] attempt
   output logic [1:0]                        rsp_tuser,   // [1:0] event_res
   input  wire                               csr_we,
   input  wire  [atrm_pkg::CsrAddrWidth-1:0] csr_addr,
   input  wire  [atrm_pkg::CsrDataWidth-1:0] csr_wdata
);
   import atrm_pkg::*;

   // configuration
   logic [ReplyWidth-1:0]   reply_ff;
   logic [RlenWidth-1:0]    rlen_ff;
   logic [TimeWidth-1:0]    timeout_ff;
   logic [TryWidth-1:0]     tries_ff;

   // exchange state
   logic                    busy_ff, busy_in;
   logic [LineLenWidth-1:0] line_len_ff, line_len_in;
   logic                    prefix_ff, prefix_in;
   logic [TimeWidth-1:0]    elapsed_ff, elapsed_in;
   logic [TryWidth-1:0]     used_ff, used_in;

   // output buffer
   logic                    out_valid_ff, out_valid_in;
   result_type              out_data_ff, out_data_in;
   logic                    skid_valid_ff, skid_valid_in;
   result_type              skid_data_ff, skid_data_in;

   logic                    accept;
   logic                    take;
   logic                    res_valid;
   result_type              res;
   cmd_type                 cmd;
   logic [ByteWidth-1:0]    rx;
   logic [RlenWidth-1:0]    rl;
   logic [ByteWidth-1:0]    want;
   logic                    pos_in_reply;
   logic                    byte_ok;
   logic                    grow_prefix;
   logic [LineLenWidth-1:0] grow_len;
   logic [TimeWidth-1:0]    elapsed_inc;

   assign accept     = req_tvalid & req_tready;
   assign take       = rsp_tvalid & rsp_tready;
   assign req_tready = !skid_valid_ff;
   assign cmd        = cmd_type'(req_tuser);
   assign rx         = req_tdata;

   assign rl = (rlen_ff > RlenWidth'(ReplyMax)) ? RlenWidth'(ReplyMax) : rlen_ff;

   assign pos_in_reply = ({{(RlenWidth > LineLenWidth ? 1 : LineLenWidth - RlenWidth + 1){1'b0}},
                            rl} > {1'b0, line_len_ff}) ? 1'b1 : 1'b0;
   assign want    = reply_ff[ByteWidth*line_len_ff[2:0] +: ByteWidth];
   assign byte_ok = (rx > ByteWidth'(CharLow)) && ({1'b0, rx} < (ByteWidth+1)'(CharHigh))
                    && (line_len_ff < LineLenWidth'(LineMax));
   assign grow_prefix = prefix_ff && pos_in_reply && (want == rx);
   assign grow_len    = line_len_ff + LineLenWidth'(1);
   assign elapsed_inc = (elapsed_ff == '1) ? elapsed_ff : elapsed_ff + TimeWidth'(1);

   always_comb begin
      busy_in       = busy_ff;
      line_len_in   = line_len_ff;
      prefix_in     = prefix_ff;
      elapsed_in    = elapsed_ff;
      used_in       = used_ff;
      res_valid     = 1'b0;
      res.event_res = EV_SEND;
      res.attempt   = used_ff;
      if (accept) begin
         case (cmd)
            CMD_START: begin
               line_len_in = '0;
               prefix_in   = 1'b1;
               elapsed_in  = '0;
               res_valid   = 1'b1;
               if (tries_ff == '0) begin
                  busy_in       = 1'b0;
                  used_in       = '0;
                  res.event_res = EV_FAIL;
                  res.attempt   = '0;
               end else begin
                  busy_in       = 1'b1;
                  used_in       = TryWidth'(1);
                  res.event_res = EV_SEND;
                  res.attempt   = TryWidth'(1);
               end
            end
            CMD_BYTE: begin
               if (busy_ff && (elapsed_ff < timeout_ff)) begin
                  if (byte_ok) begin
                     if (grow_prefix && ({1'b0, grow_len} ==
                         (LineLenWidth+1)'(rl))) begin
                        busy_in       = 1'b0;
                        line_len_in   = '0;
                        prefix_in     = 1'b1;
                        res_valid     = 1'b1;
                        res.event_res = EV_MATCH;
                     end else begin
                        line_len_in = grow_len;
                        prefix_in   = grow_prefix;
                     end
                  end else begin
                     // compare before clearing: an empty reply matches here
                     line_len_in = '0;
                     prefix_in   = 1'b1;
                     if (prefix_ff && ({1'b0, line_len_ff} ==
                         (LineLenWidth+1)'(rl))) begin
                        busy_in       = 1'b0;
                        res_valid     = 1'b1;
                        res.event_res = EV_MATCH;
                     end
                  end
               end
            end
            CMD_TICK: begin
               if (busy_ff) begin
                  if (elapsed_inc < timeout_ff) begin
                     elapsed_in = elapsed_inc;
                  end else begin
                     line_len_in = '0;
                     prefix_in   = 1'b1;
                     elapsed_in  = '0;
                     res_valid   = 1'b1;
                     if (used_ff < tries_ff) begin
                        used_in       = used_ff + TryWidth'(1);
                        res.event_res = EV_SEND;
                        res.attempt   = used_ff + TryWidth'(1);
                     end else begin
                        busy_in       = 1'b0;
                        res.event_res = EV_FAIL;
                     end
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // output register with a skid entry behind it
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (!out_valid_ff || take) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = res_valid;
            out_data_in  = res;
         end
      end else if (res_valid) begin
         skid_valid_in = 1'b1;
         skid_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reply_ff   <= ReplyReset;
         rlen_ff    <= RlenReset;
         timeout_ff <= TimeoutReset;
         tries_ff   <= TriesReset;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            REG_EXPECTED_REPLY: reply_ff   <= csr_wdata[ReplyWidth-1:0];
            REG_REPLY_LENGTH:   rlen_ff    <= csr_wdata[RlenWidth-1:0];
            REG_TIMEOUT_MS:     timeout_ff <= csr_wdata[TimeWidth-1:0];
            REG_MAX_TRIES:      tries_ff   <= csr_wdata[TryWidth-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff       <= 1'b0;
         line_len_ff   <= '0;
         prefix_ff     <= 1'b1;
         elapsed_ff    <= '0;
         used_ff       <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         busy_ff       <= busy_in;
         line_len_ff   <= line_len_in;
         prefix_ff     <= prefix_in;
         elapsed_ff    <= elapsed_in;
         used_ff       <= used_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff.attempt;
   assign rsp_tuser  = out_data_ff.event_res;

   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_line_bound: assert property (@(posedge clock) disable iff (reset)
      line_len_ff <= LineLenWidth'(LineMax))
      else $error("line longer than its limit");

   a_idle_line_clear: assert property (@(posedge clock) disable iff (reset)
      !busy_ff |-> (line_len_ff == '0 && prefix_ff))
      else $error("line not cleared while no exchange is open");

   // max_tries may be lowered mid-exchange, so only a nonzero attempt is implied
   a_busy_has_attempt: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (used_ff != '0))
      else $error("open exchange without a valid attempt number");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && skid_valid_ff && !rsp_tready) |=> $stable(out_data_ff))
      else $error("output item changed while stalled");

endmodule

`default_nettype wire

FILE: tb/tb_at_reply_matcher_with_retry.sv
`default_nettype none

module tb_at_reply_matcher_with_retry;
   import atrm_pkg::*;

   localparam logic [1:0] CMD_UNUSED    = 2'd3;
   localparam int         HoldCycles    = 300;
   localparam int         WatchdogLimit = 4000;
   localparam int         SettleCycles  = 4;

   typedef struct {
      logic [1:0] cmd;
      logic [7:0] rx_byte;
   } req_item_type;

   logic                    clock      = 1'b0;
   logic                    reset      = 1'b1;
   logic                    req_tvalid = 1'b0;
   logic                    req_tready;
   logic [7:0]              req_tdata  = '0;
   logic [1:0]              req_tuser  = '0;
   logic                    rsp_tvalid;
   logic                    rsp_tready = 1'b0;
   logic [7:0]              rsp_tdata;
   logic [1:0]              rsp_tuser;
   logic                    csr_we     = 1'b0;
   logic [CsrAddrWidth-1:0] csr_addr   = '0;
   logic [CsrDataWidth-1:0] csr_wdata  = '0;

   at_reply_matcher_with_retry u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   // register copies
   logic [63:0] reg_reply   = ReplyReset;
   logic [3:0]  reg_rlen    = RlenReset;
   logic [31:0] reg_timeout = TimeoutReset;
   logic [7:0]  reg_tries   = TriesReset;

   // exchange state as the block should hold it
   logic        ex_open    = 1'b0;
   logic [4:0]  line_len   = '0;
   logic        line_ok    = 1'b1;
   logic [31:0] ms_elapsed = '0;
   logic [7:0]  tries_used = '0;

   req_item_type rx_items[$];
   result_type   due_events[$];
   req_item_type on_bus;
   result_type   head_event;

   int send_idle_pct = 0;
   int rsp_stall_pct = 0;
   int hold_trigger  = 0;
   int hold_seen     = 0;
   int hold_left     = 0;
   int mismatch_count = 0;
   int quiet_cycles  = 0;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [3:0] reply_chars();
      return (reg_rlen > ReplyMax) ? 4'(ReplyMax) : reg_rlen;
   endfunction

   function automatic void clear_line();
      line_len = '0;
      line_ok  = 1'b1;
   endfunction

   function automatic void log_event(input event_type ev, input logic [7:0] att);
      due_events.push_back('{event_res: ev, attempt: att});
   endfunction

   function automatic void track_item(input req_item_type it);
      logic [3:0] rl;
      logic       rejected;
      rl = reply_chars();
      case (it.cmd)
         CMD_START: begin
            clear_line();
            ms_elapsed = '0;
            if (reg_tries == '0) begin
               ex_open    = 1'b0;
               tries_used = '0;
               log_event(EV_FAIL, '0);
            end else begin
               ex_open    = 1'b1;
               tries_used = 8'd1;
               log_event(EV_SEND, tries_used);
            end
         end
         CMD_BYTE: begin
            // bytes after the timeout are ignored until the next tick ends the attempt
            if (ex_open && ms_elapsed < reg_timeout) begin
               rejected = !(it.rx_byte > CharLow && it.rx_byte < CharHigh
                            && line_len < LineMax);
               if (!rejected) begin
                  if (line_len < rl && line_len < ReplyMax) begin
                     if (reg_reply[8*line_len +: 8] != it.rx_byte) line_ok = 1'b0;
                  end else begin
                     line_ok = 1'b0;
                  end
                  line_len = line_len + 5'd1;
               end
               // compare before a rejected byte clears the line
               if (line_ok && line_len == rl) begin
                  ex_open = 1'b0;
                  clear_line();
                  log_event(EV_MATCH, tries_used);
               end else if (rejected) begin
                  clear_line();
               end
            end
         end
         CMD_TICK: begin
            if (ex_open) begin
               if (ms_elapsed != '1) ms_elapsed = ms_elapsed + 32'd1;
               if (ms_elapsed >= reg_timeout) begin
                  clear_line();
                  ms_elapsed = '0;
                  if (tries_used < reg_tries) begin
                     tries_used = tries_used + 8'd1;
                     log_event(EV_SEND, tries_used);
                  end else begin
                     ex_open = 1'b0;
                     log_event(EV_FAIL, tries_used);
                  end
               end
            end
         end
         default: ;
      endcase
   endfunction

   task automatic report_mismatch(input string what, input logic [7:0] got,
                                  input logic [7:0] want);
      $display("mismatch at %0t: %s got %0d want %0d", $time, what, got, want);
      mismatch_count++;
   endtask

   // driver: advance on acceptance, then offer the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) track_item(on_bus);
         if (!req_tvalid || req_tready) begin
            if (rx_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               on_bus = rx_items.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= on_bus.rx_byte;
               req_tuser  <= on_bus.cmd;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: check each accepted result, then choose the next ready
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (due_events.size() == 0) begin
               report_mismatch("result with none expected", rsp_tdata, '0);
            end else begin
               head_event = due_events.pop_front();
               if (rsp_tuser !== head_event.event_res)
                  report_mismatch("event_res", {6'd0, rsp_tuser},
                                  {6'd0, head_event.event_res});
               if (rsp_tdata !== head_event.attempt)
                  report_mismatch("attempt", rsp_tdata, head_event.attempt);
            end
         end
         if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = HoldCycles;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WatchdogLimit) begin
            $display("timeout: no item moved for %0d cycles", WatchdogLimit);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   task automatic write_reg(input csr_index_type idx, input logic [63:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we    <= 1'b0;
      case (idx)
         REG_EXPECTED_REPLY: reg_reply   = val;
         REG_REPLY_LENGTH:   reg_rlen    = val[3:0];
         REG_TIMEOUT_MS:     reg_timeout = val[31:0];
         REG_MAX_TRIES:      reg_tries   = val[7:0];
         default: ;
      endcase
   endtask

   task automatic configure(input logic [63:0] reply, input logic [3:0] rlen,
                            input logic [31:0] tmo, input logic [7:0] tries);
      write_reg(REG_EXPECTED_REPLY, reply);
      write_reg(REG_REPLY_LENGTH, 64'(rlen));
      write_reg(REG_TIMEOUT_MS, 64'(tmo));
      write_reg(REG_MAX_TRIES, 64'(tries));
      @(negedge clock);
   endtask

   // hold until every item is sent and every result is back, then settle
   task automatic wait_drained();
      do @(negedge clock);
      while (rx_items.size() != 0 || req_tvalid || due_events.size() != 0);
      repeat (SettleCycles) @(negedge clock);
   endtask

   function automatic void queue_item(input logic [1:0] cmd, input logic [7:0] b);
      rx_items.push_back('{cmd: cmd, rx_byte: b});
   endfunction

   function automatic logic [7:0] junk_byte();
      return $urandom_range(1) ? 8'($urandom_range(25)) : 8'($urandom_range(128, 255));
   endfunction

   function automatic logic [63:0] random_reply();
      logic [63:0] r;
      for (int i = 0; i < 8; i++) r[8*i +: 8] = 8'($urandom_range(26, 127));
      return r;
   endfunction

   // one exchange: mostly a start followed by a reply line, sometimes noise
   function automatic int queue_exchange();
      int         n;
      int         mode;
      logic [3:0] rl;
      logic [7:0] c;
      n  = 0;
      rl = reply_chars();
      if ($urandom_range(9) == 0) begin
         queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
         return 1;
      end
      queue_item(CMD_START, 8'($urandom_range(255)));
      n++;
      mode = $urandom_range(9);
      if (mode < 6) begin
         repeat ($urandom_range(2)) begin
            queue_item(CMD_BYTE, junk_byte());
            n++;
         end
         if ($urandom_range(3) == 0) begin
            queue_item(CMD_TICK, 8'($urandom_range(255)));
            n++;
         end
         for (int i = 0; i < rl; i++) begin
            c = reg_reply[8*i +: 8];
            if ($urandom_range(99) < 15) c = 8'($urandom_range(255));
            queue_item(CMD_BYTE, c);
            n++;
            if ($urandom_range(9) == 0) begin
               queue_item(CMD_TICK, 8'($urandom_range(255)));
               n++;
            end
         end
         queue_item(CMD_BYTE, 8'h0D);
         n++;
      end else if (mode < 8) begin
         repeat ($urandom_range(1, 8)) begin
            queue_item(CMD_TICK, 8'($urandom_range(255)));
            n++;
         end
      end else if (mode == 8) begin
         // run the line up to or past its limit
         repeat ($urandom_range(18, 22)) begin
            queue_item(CMD_BYTE, 8'($urandom_range(26, 127)));
            n++;
         end
      end else begin
         repeat ($urandom_range(1, 6)) begin
            queue_item(2'($urandom_range(3)), 8'($urandom_range(255)));
            n++;
         end
      end
      return n;
   endfunction

   task automatic run_phase(input logic [63:0] reply, input logic [3:0] rlen,
                            input logic [31:0] tmo, input logic [7:0] tries,
                            input int snd_idle, input int rcv_stall, input int n_items,
                            input bit with_hold);
      int made;
      configure(reply, rlen, tmo, tries);
      send_idle_pct = snd_idle;
      rsp_stall_pct = rcv_stall;
      if (with_hold) hold_trigger++;
      made = 0;
      while (made < n_items) made += queue_exchange();
      wait_drained();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // basic exchanges on the reply "OK"
      configure(64'h4B4F, 4'd2, 32'd3, 8'd2);
      queue_item(CMD_BYTE, 8'h4F);
      queue_item(CMD_TICK, 8'h00);
      queue_item(CMD_UNUSED, 8'hFF);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_BYTE, 8'h4F);
      queue_item(CMD_BYTE, 8'h4B);
      queue_item(CMD_START, 8'hFF);
      queue_item(CMD_BYTE, 8'h00);
      queue_item(CMD_BYTE, 8'hFF);
      queue_item(CMD_BYTE, 8'h4F);
      queue_item(CMD_UNUSED, 8'h4B);
      queue_item(CMD_BYTE, 8'h4B);
      queue_item(CMD_START, 8'h55);
      repeat (6) queue_item(CMD_TICK, 8'hAA);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_BYTE, 8'd26);
      queue_item(CMD_BYTE, 8'd127);
      queue_item(CMD_BYTE, 8'd25);
      queue_item(CMD_BYTE, 8'd128);
      wait_drained();

      // empty reply: a rejected byte on an empty line matches
      configure(64'h4B4F, 4'd0, 32'd5, 8'd1);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_BYTE, 8'h0D);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_BYTE, 8'h41);
      queue_item(CMD_BYTE, 8'h0A);
      wait_drained();

      // no tries at all
      configure(64'h4B4F, 4'd2, 32'd5, 8'd0);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_BYTE, 8'h4F);
      wait_drained();

      // zero timeout: bytes ignored, each tick ends an attempt
      configure(64'h4B4F, 4'd2, 32'd0, 8'd2);
      queue_item(CMD_START, 8'h00);
      queue_item(CMD_BYTE, 8'h4F);
      queue_item(CMD_TICK, 8'h00);
      queue_item(CMD_TICK, 8'h00);
      wait_drained();

      // lower the timeout while an attempt is open
      configure(64'h4B4F, 4'd2, 32'd10, 8'd2);
      queue_item(CMD_START, 8'h00);
      repeat (5) queue_item(CMD_TICK, 8'h00);
      wait_drained();
      write_reg(REG_TIMEOUT_MS, 64'd2);
      @(negedge clock);
      queue_item(CMD_BYTE, 8'h4F);
      queue_item(CMD_TICK, 8'h00);
      queue_item(CMD_TICK, 8'h00);
      queue_item(CMD_TICK, 8'h00);
      wait_drained();

      run_phase(64'h4B4F, 4'd2, 32'd4, 8'd3, 0, 0, 30, 1'b0);
      run_phase(64'h524F525245, 4'd5, 32'd6, 8'd2, 74, 0, 30, 1'b0);
      run_phase(random_reply(), 4'd8, 32'd3, 8'd1, 0, 74, 30, 1'b0);
      run_phase(random_reply(), 4'd15, 32'd2, 8'd255, 37, 37, 30, 1'b0);
      run_phase('1, 4'd8, 32'd1, 8'd4, 0, 0, 25, 1'b0);
      run_phase(64'h0, 4'd1, 32'hFFFF_FFFF, 8'd1, 74, 0, 25, 1'b0);
      run_phase(random_reply(), 4'($urandom_range(1, 8)), 32'd5,
                8'($urandom_range(1, 4)), 0, 74, 30, 1'b0);
      // receiver holds off while the sender keeps going
      run_phase(64'h4B4F, 4'd2, 32'd2, 8'd2, 0, 0, 28, 1'b1);

      // every attempt used up
      configure(64'h4B4F, 4'd2, 32'd1, 8'd255);
      send_idle_pct = 37;
      rsp_stall_pct = 37;
      queue_item(CMD_START, 8'h00);
      repeat (256) queue_item(CMD_TICK, 8'($urandom_range(255)));
      wait_drained();

      if (mismatch_count == 0 && due_events.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

`default_nettype wire
